// File: design/paf_pkg.sv
package paf_pkg;

    // Default sizes of the archive
    localparam int ARCHIVE_DEPTH_DEF  = 64;
    localparam int MAX_OBJECTIVES_DEF = 4;
    localparam int SOLUTION_BITS_DEF  = 64;

    // Fixed widths of the beat fields
    localparam int OBJ_W         = 32;
    localparam int IN_OBJ_COUNT  = 4;
    localparam int SOL_W         = 64;
    localparam int IDX_W         = 6;
    localparam int COUNT_W       = 7;
    localparam int NUM_OBJ_W     = 3;

    localparam logic [NUM_OBJ_W-1:0] NUM_OBJ_RESET = 3'd2;

    // Command codes
    localparam logic CMD_OFFER = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic                    cmd;
        logic [IDX_W-1:0]        read_index;
        logic [SOL_W-1:0]        sol_bits;
        logic signed [OBJ_W-1:0] obj_a;
        logic signed [OBJ_W-1:0] obj_b;
        logic signed [OBJ_W-1:0] obj_c;
        logic signed [OBJ_W-1:0] obj_d;
    } t_item;

    typedef struct packed {
        logic                    accepted;
        logic [COUNT_W-1:0]      removed_count;
        logic [COUNT_W-1:0]      archive_count;
        logic                    overflow;
        logic                    entry_valid;
        logic [SOL_W-1:0]        entry_sol;
        logic signed [OBJ_W-1:0] entry_obj_a;
        logic signed [OBJ_W-1:0] entry_obj_b;
        logic signed [OBJ_W-1:0] entry_obj_c;
        logic signed [OBJ_W-1:0] entry_obj_d;
    } t_result;

    // Per-component compare of candidate against one stored entry
    typedef struct packed {
        logic ge;   // candidate >= entry (or lane disabled)
        logic le;   // candidate <= entry (or lane disabled)
    } t_lane_cmp;

    // Merged dominance verdict for one entry
    typedef struct packed {
        logic cand_dom;    // candidate dominates the entry
        logic entry_dom;   // entry dominates the candidate
    } t_dom;

endpackage

// File: design/paf_lane.sv
module paf_lane
    import paf_pkg::*;
(
    input  logic                    i_clk,
    input  logic signed [OBJ_W-1:0] i_cand,
    input  logic signed [OBJ_W-1:0] i_entry,
    input  logic                    i_active,
    output t_lane_cmp               o_cmp
);

    t_lane_cmp r_cmp;

    // A disabled lane reads as equal so it never decides dominance
    always_ff @(posedge i_clk) begin
        r_cmp.ge <= !i_active || (i_cand >= i_entry);
        r_cmp.le <= !i_active || (i_cand <= i_entry);
    end

    assign o_cmp = r_cmp;

endmodule

// File: design/paf_merge.sv
module paf_merge
    import paf_pkg::*;
#(
    parameter int MAX_OBJECTIVES = MAX_OBJECTIVES_DEF
) (
    input  t_lane_cmp [MAX_OBJECTIVES-1:0] i_cmp,
    output t_dom                           o_dom
);

    logic all_ge;
    logic all_le;
    logic any_gt;
    logic any_lt;

    always_comb begin
        all_ge = 1'b1;
        all_le = 1'b1;
        any_gt = 1'b0;
        any_lt = 1'b0;
        for (int i = 0; i < MAX_OBJECTIVES; i++) begin
            all_ge = all_ge & i_cmp[i].ge;
            all_le = all_le & i_cmp[i].le;
            any_gt = any_gt | !i_cmp[i].le;
            any_lt = any_lt | !i_cmp[i].ge;
        end
        o_dom.cand_dom  = all_ge && any_gt;
        o_dom.entry_dom = all_le && any_lt;
    end

endmodule

// File: design/paf_store.sv
module paf_store
    import paf_pkg::*;
#(
    parameter int ARCHIVE_DEPTH  = ARCHIVE_DEPTH_DEF,
    parameter int MAX_OBJECTIVES = MAX_OBJECTIVES_DEF,
    parameter int SOLUTION_BITS  = SOLUTION_BITS_DEF,
    localparam int ADDR_W        = (ARCHIVE_DEPTH > 1) ? $clog2(ARCHIVE_DEPTH) : 1,
    localparam int OBJV_W        = MAX_OBJECTIVES * OBJ_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [ADDR_W-1:0]        i_wr_addr,
    input  logic [SOLUTION_BITS-1:0] i_wr_sol,
    input  logic [OBJV_W-1:0]        i_wr_obj,
    input  logic [ADDR_W-1:0]        i_rd_addr,
    output logic [SOLUTION_BITS-1:0] o_rd_sol,
    output logic [OBJV_W-1:0]        o_rd_obj
);

    logic [SOLUTION_BITS-1:0] r_sol_mem [ARCHIVE_DEPTH];
    logic [OBJV_W-1:0]        r_obj_mem [ARCHIVE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_sol_mem[i_wr_addr] <= i_wr_sol;
            r_obj_mem[i_wr_addr] <= i_wr_obj;
        end
        o_rd_sol <= r_sol_mem[i_rd_addr];
        o_rd_obj <= r_obj_mem[i_rd_addr];
    end

endmodule

// File: design/pareto_archive_filter_core.sv
// Pareto archive filter: holds up to ARCHIVE_DEPTH non-dominated entries (solution bits plus
// MAX_OBJECTIVES signed objectives, all maximized) and answers one command beat at a time.
// An offer beat walks the whole archive, one slot per cycle out of the entry memory, with one
// compare lane per objective and a merge stage that forms the dominance verdict; it then commits,
// and busy stays high through the walk and the commit, so no new beat is taken. A read beat keeps
// busy high only while in S_READ. Each result shows on o_result for exactly one cycle with o_done
// high, and it must be taken then: there is no back-pressure. The valid map is flip-flops and is
// cleared by reset at once; the entry memory holds no reset value and its data is only used for
// valid slots. Write num_objectives (i_cfg_we, i_cfg_wdata) only while busy is low.
module pareto_archive_filter_core
    import paf_pkg::*;
#(
    parameter int ARCHIVE_DEPTH  = ARCHIVE_DEPTH_DEF,
    parameter int MAX_OBJECTIVES = MAX_OBJECTIVES_DEF,
    parameter int SOLUTION_BITS  = SOLUTION_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_item                i_item,
    input  logic                 i_cfg_we,
    input  logic [NUM_OBJ_W-1:0] i_cfg_wdata,
    output logic                 o_done,
    output t_result              o_result
);

    localparam int ADDR_W  = (ARCHIVE_DEPTH > 1) ? $clog2(ARCHIVE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(ARCHIVE_DEPTH + 1);
    localparam int OBJV_W  = MAX_OBJECTIVES * OBJ_W;
    localparam int OUT_OBJ = (MAX_OBJECTIVES < IN_OBJ_COUNT) ? MAX_OBJECTIVES : IN_OBJ_COUNT;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_WAIT,
        S_COMMIT
    } t_state;

    t_state r_state, n_state;
    logic    r_done, n_done;
    t_result r_result, n_result;

    // Configuration
    logic [NUM_OBJ_W-1:0]      r_num_obj;
    logic [MAX_OBJECTIVES-1:0] w_lane_act;

    // Archive bookkeeping
    logic [ARCHIVE_DEPTH-1:0] r_valid;
    logic [CNT_W-1:0]         r_valid_total;
    logic [ARCHIVE_DEPTH-1:0] w_set_mask;

    // Candidate held for the walk
    logic signed [OBJ_W-1:0]  r_cand_obj [MAX_OBJECTIVES];
    logic [SOLUTION_BITS-1:0] r_cand_sol;
    logic [OBJV_W-1:0]        w_cand_flat;
    logic signed [OBJ_W-1:0]  w_in_obj [IN_OBJ_COUNT];

    // Walk pipeline: issue, memory data, lane compare
    logic [ADDR_W-1:0] r_scan_addr;
    logic              r_p1_vld, r_p2_vld;
    logic [ADDR_W-1:0] r_p1_idx, r_p2_idx;
    logic              r_p1_slotv, r_p2_slotv;

    // Walk accumulators
    logic                     r_dropped;
    logic [ARCHIVE_DEPTH-1:0] r_kill;
    logic [CNT_W-1:0]         r_removed;
    logic                     r_free_found;
    logic [ADDR_W-1:0]        r_free_slot;

    // Read command
    logic r_rd_ok;
    logic w_idx_in_range;

    // Memory ports
    logic                     w_we;
    logic [ADDR_W-1:0]        w_rd_addr;
    logic [SOLUTION_BITS-1:0] w_rd_sol;
    logic [OBJV_W-1:0]        w_rd_obj;

    t_lane_cmp [MAX_OBJECTIVES-1:0] w_cmp;
    t_dom                           w_dom;

    logic w_accept;
    logic w_last_issue;
    logic w_last_done;
    logic w_place;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign o_done   = r_done;
    assign o_result = r_result;

    // ------------------------------------------------------------------
    // Configuration register and lane enables. A count of zero acts as
    // one, and lanes past MAX_OBJECTIVES do not exist, so the clamp is free.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_obj <= NUM_OBJ_RESET;
        end else if (i_cfg_we) begin
            r_num_obj <= i_cfg_wdata;
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_OBJECTIVES; i++) begin
            w_lane_act[i] = (i == 0) || (i < int'(r_num_obj));
        end
    end

    // ------------------------------------------------------------------
    // Candidate capture. Components beyond the four input fields are zero.
    // ------------------------------------------------------------------
    always_comb begin
        w_in_obj[0] = i_item.obj_a;
        w_in_obj[1] = i_item.obj_b;
        w_in_obj[2] = i_item.obj_c;
        w_in_obj[3] = i_item.obj_d;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_item.cmd == CMD_OFFER) begin
            for (int i = 0; i < MAX_OBJECTIVES; i++) begin
                if (i < OUT_OBJ) begin
                    r_cand_obj[i] <= w_in_obj[i];
                end else begin
                    r_cand_obj[i] <= '0;
                end
            end
            r_cand_sol <= i_item.sol_bits[SOLUTION_BITS-1:0];
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_OBJECTIVES; i++) begin
            w_cand_flat[i*OBJ_W +: OBJ_W] = r_cand_obj[i];
        end
    end

    // ------------------------------------------------------------------
    // Entry memory. The read port serves the read command while idle and
    // the walk otherwise; the only write is the commit.
    // ------------------------------------------------------------------
    assign w_idx_in_range = (int'(i_item.read_index) < ARCHIVE_DEPTH);
    assign w_rd_addr      = (r_state == S_IDLE) ? ADDR_W'(i_item.read_index) : r_scan_addr;
    assign w_place        = !r_dropped && r_free_found;
    assign w_we           = (r_state == S_COMMIT) && w_place;

    paf_store #(
        .ARCHIVE_DEPTH (ARCHIVE_DEPTH),
        .MAX_OBJECTIVES(MAX_OBJECTIVES),
        .SOLUTION_BITS (SOLUTION_BITS)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_wr_addr(r_free_slot),
        .i_wr_sol (r_cand_sol),
        .i_wr_obj (w_cand_flat),
        .i_rd_addr(w_rd_addr),
        .o_rd_sol (w_rd_sol),
        .o_rd_obj (w_rd_obj)
    );

    // ------------------------------------------------------------------
    // One compare lane per objective, then the merge into a verdict.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < MAX_OBJECTIVES; g++) begin : g_lane
        paf_lane u_lane (
            .i_clk   (i_clk),
            .i_cand  (r_cand_obj[g]),
            .i_entry (w_rd_obj[g*OBJ_W +: OBJ_W]),
            .i_active(w_lane_act[g]),
            .o_cmp   (w_cmp[g])
        );
    end

    paf_merge #(
        .MAX_OBJECTIVES(MAX_OBJECTIVES)
    ) u_merge (
        .i_cmp(w_cmp),
        .o_dom(w_dom)
    );

    // ------------------------------------------------------------------
    // Walk pipeline tags: track which slot sits in each stage, and
    // whether it was valid when it was issued.
    // ------------------------------------------------------------------
    assign w_last_issue = (r_scan_addr == ADDR_W'(ARCHIVE_DEPTH - 1));
    assign w_last_done  = r_p2_vld && (r_p2_idx == ADDR_W'(ARCHIVE_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            r_p1_vld <= (r_state == S_SCAN);
            r_p2_vld <= r_p1_vld;
        end
        r_p1_idx   <= r_scan_addr;
        r_p1_slotv <= r_valid[r_scan_addr];
        r_p2_idx   <= r_p1_idx;
        r_p2_slotv <= r_p1_slotv;
    end

    // ------------------------------------------------------------------
    // Walk accumulators. The lowest slot that is free, or that the
    // candidate would clear, is the landing slot.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_addr  <= '0;
            r_dropped    <= 1'b0;
            r_kill       <= '0;
            r_removed    <= '0;
            r_free_found <= 1'b0;
            r_free_slot  <= '0;
        end else if (w_accept && i_item.cmd == CMD_OFFER) begin
            r_scan_addr  <= '0;
            r_dropped    <= 1'b0;
            r_kill       <= '0;
            r_removed    <= '0;
            r_free_found <= 1'b0;
        end else begin
            if (r_state == S_SCAN && !w_last_issue) begin
                r_scan_addr <= r_scan_addr + 1'b1;
            end
            if (r_p2_vld) begin
                if (r_p2_slotv && w_dom.entry_dom) begin
                    r_dropped <= 1'b1;
                end
                if (r_p2_slotv && w_dom.cand_dom) begin
                    r_kill[r_p2_idx] <= 1'b1;
                    r_removed        <= r_removed + 1'b1;
                end
                if (!r_free_found && (!r_p2_slotv || w_dom.cand_dom)) begin
                    r_free_found <= 1'b1;
                    r_free_slot  <= r_p2_idx;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Valid map and entry count: change only at commit of a kept candidate.
    // Clear the dominated slots and mark the landing slot in one update.
    // ------------------------------------------------------------------
    assign w_set_mask = r_free_found ? (ARCHIVE_DEPTH'(1) << r_free_slot) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_valid_total <= '0;
        end else if (r_state == S_COMMIT && !r_dropped) begin
            r_valid       <= (r_valid & ~r_kill) | w_set_mask;
            r_valid_total <= r_valid_total - r_removed + CNT_W'(r_free_found);
        end
    end

    // Read command: latch whether the slot is in range and valid
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_ok <= w_idx_in_range && r_valid[ADDR_W'(i_item.read_index)];
        end
    end

    // ------------------------------------------------------------------
    // Control and result beat
    // ------------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_result = r_result;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_item.cmd == CMD_READ) ? S_READ : S_SCAN;
                end
            end
            S_READ: begin
                n_result               = '0;
                n_result.archive_count = COUNT_W'(r_valid_total);
                if (r_rd_ok) begin
                    n_result.entry_valid = 1'b1;
                    n_result.entry_sol   = SOL_W'(w_rd_sol);
                    if (OUT_OBJ > 0) n_result.entry_obj_a = w_rd_obj[0*OBJ_W +: OBJ_W];
                    if (OUT_OBJ > 1) n_result.entry_obj_b = w_rd_obj[1*OBJ_W +: OBJ_W];
                    if (OUT_OBJ > 2) n_result.entry_obj_c = w_rd_obj[2*OBJ_W +: OBJ_W];
                    if (OUT_OBJ > 3) n_result.entry_obj_d = w_rd_obj[3*OBJ_W +: OBJ_W];
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (w_last_issue) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_last_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                n_result = '0;
                if (r_dropped) begin
                    n_result.archive_count = COUNT_W'(r_valid_total);
                end else begin
                    n_result.accepted      = r_free_found;
                    n_result.overflow      = !r_free_found;
                    n_result.removed_count = COUNT_W'(r_removed);
                    n_result.archive_count = COUNT_W'(r_valid_total - r_removed
                                                      + CNT_W'(r_free_found));
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_result <= n_result;
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_done_when_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_state == S_IDLE))
        else $error("result beat outside idle");

    a_accept_overflow_excl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_result.accepted && o_result.overflow))
        else $error("accepted and overflow both set");

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_valid_total) <= ARCHIVE_DEPTH)
        else $error("valid count above archive depth");

    a_count_matches_map : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_valid) == int'(r_valid_total)))
        else $error("valid count disagrees with valid map");

    a_dropped_keeps_map : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT && r_dropped) |=> $stable(r_valid))
        else $error("dominated candidate changed the archive");

endmodule

// File: tb/sv/archive_scoreboard_pkg.sv
`timescale 1ns / 1ps

package archive_scoreboard_pkg;
    import paf_pkg::*;

    typedef logic signed [OBJ_W-1:0] t_objs [IN_OBJ_COUNT];

    localparam int SLOTS      = ARCHIVE_DEPTH_DEF;
    localparam int OBJ_TOP    = 32'sh7FFF_FFFF;
    localparam int OBJ_BOTTOM = -32'sh7FFF_FFFF - 1;

    class archive_scoreboard;
        bit                   slot_live    [SLOTS];
        bit                   slot_touched [SLOTS];
        logic [SOL_W-1:0]     slot_sol     [SLOTS];
        t_objs                slot_obj     [SLOTS];
        int                   live_total;
        int                   touched_total;
        logic [NUM_OBJ_W-1:0] obj_count_reg;
        t_result              pending [$];
        int unsigned          mismatches;

        function new();
            obj_count_reg = NUM_OBJ_RESET;
            live_total    = 0;
            touched_total = 0;
            mismatches    = 0;
            foreach (slot_live[s]) begin
                slot_live[s]    = 1'b0;
                slot_touched[s] = 1'b0;
            end
        endfunction

        function int unsigned active_lanes();
            if (obj_count_reg == 0)
                return 1;
            if (obj_count_reg > MAX_OBJECTIVES_DEF)
                return MAX_OBJECTIVES_DEF;
            return obj_count_reg;
        endfunction

        // p dominates q: no lane worse, at least one lane strictly better
        function bit beats(t_objs p, t_objs q, int unsigned lanes);
            bit strictly = 1'b0;
            for (int i = 0; i < lanes; i++) begin
                if (p[i] < q[i])
                    return 1'b0;
                if (p[i] > q[i])
                    strictly = 1'b1;
            end
            return strictly;
        endfunction

        // Update the archive copy for one accepted beat and queue its result
        function void note_item(t_item beat);
            t_result     r;
            t_objs       cand;
            int unsigned lanes;
            int unsigned removed;
            bit          dropped;
            bit          placed;
            r       = '0;
            removed = 0;
            dropped = 1'b0;
            placed  = 1'b0;
            if (beat.cmd == CMD_READ) begin
                if (slot_live[beat.read_index]) begin
                    r.entry_valid = 1'b1;
                    r.entry_sol   = slot_sol[beat.read_index];
                    r.entry_obj_a = slot_obj[beat.read_index][0];
                    r.entry_obj_b = slot_obj[beat.read_index][1];
                    r.entry_obj_c = slot_obj[beat.read_index][2];
                    r.entry_obj_d = slot_obj[beat.read_index][3];
                end
            end else begin
                cand[0] = beat.obj_a;
                cand[1] = beat.obj_b;
                cand[2] = beat.obj_c;
                cand[3] = beat.obj_d;
                lanes   = active_lanes();
                foreach (slot_live[s])
                    if (slot_live[s] && beats(slot_obj[s], cand, lanes))
                        dropped = 1'b1;
                if (!dropped) begin
                    foreach (slot_live[s]) begin
                        if (slot_live[s] && beats(cand, slot_obj[s], lanes)) begin
                            slot_live[s] = 1'b0;
                            removed++;
                            live_total--;
                        end
                    end
                    for (int s = 0; s < SLOTS && !placed; s++) begin
                        if (!slot_live[s]) begin
                            slot_live[s] = 1'b1;
                            slot_sol[s]  = beat.sol_bits;
                            slot_obj[s]  = cand;
                            if (!slot_touched[s])
                                touched_total++;
                            slot_touched[s] = 1'b1;
                            live_total++;
                            placed = 1'b1;
                        end
                    end
                    r.accepted = placed;
                    r.overflow = !placed;
                end
                r.removed_count = COUNT_W'(removed);
            end
            r.archive_count = COUNT_W'(live_total);
            pending = {pending, r};
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                $error("result beat with nothing outstanding");
                mismatches++;
                return;
            end
            want = pending.pop_front();
            compare("accepted",      want.accepted,      got.accepted);
            compare("removed_count", want.removed_count, got.removed_count);
            compare("archive_count", want.archive_count, got.archive_count);
            compare("overflow",      want.overflow,      got.overflow);
            compare("entry_valid",   want.entry_valid,   got.entry_valid);
            compare("entry_sol",     want.entry_sol,     got.entry_sol);
            compare("entry_obj_a",   want.entry_obj_a,   got.entry_obj_a);
            compare("entry_obj_b",   want.entry_obj_b,   got.entry_obj_b);
            compare("entry_obj_c",   want.entry_obj_c,   got.entry_obj_c);
            compare("entry_obj_d",   want.entry_obj_d,   got.entry_obj_d);
        endfunction

        // Random live entry, or the one leading in lane 0
        function bit pick_live(output t_objs v, input bit by_lane0);
            int idx;
            if (live_total == 0)
                return 1'b0;
            idx = -1;
            if (by_lane0) begin
                foreach (slot_live[s])
                    if (slot_live[s] && (idx < 0 || slot_obj[s][0] > slot_obj[idx][0]))
                        idx = s;
            end else begin
                do idx = $urandom_range(SLOTS - 1); while (!slot_live[idx]);
            end
            v = slot_obj[idx];
            return 1'b1;
        endfunction

        // Random slot that has held an entry at some point, -1 if none has
        function int pick_touched();
            int idx;
            if (touched_total == 0)
                return -1;
            do idx = $urandom_range(SLOTS - 1); while (!slot_touched[idx]);
            return idx;
        endfunction
    endclass

endpackage

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import paf_pkg::*;
    import archive_scoreboard_pkg::*;

    localparam int STALL_LIMIT  = 2000;                   // cycles with no beat moving
    localparam int DRAIN_CYCLES = ARCHIVE_DEPTH_DEF + 8;  // one full offer scan and margin

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_item                i_item;
    logic                 i_cfg_we;
    logic [NUM_OBJ_W-1:0] i_cfg_wdata;
    logic                 o_done;
    t_result              o_result;

    archive_scoreboard archive_sb;
    int unsigned       sender_idle_pct;
    int unsigned       quiet_cycles = 0;

    pareto_archive_filter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Check every result beat against the oldest expectation. There is no
    // back-pressure, so a beat is taken whenever o_done is high. Also run the
    // watchdog: count cycles in which neither a command nor a result moves.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                archive_sb.check_result(o_result);
            if (o_done || (start && !busy)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Clamp to the signed 32-bit range so extremes stick instead of wrapping.
    function automatic int nudge(int v, int delta);
        longint t;
        t = longint'(v) + longint'(delta);
        if (t > OBJ_TOP)
            return OBJ_TOP;
        if (t < OBJ_BOTTOM)
            return OBJ_BOTTOM;
        return int'(t);
    endfunction

    function automatic logic [SOL_W-1:0] any_sol();
        return {$urandom, $urandom};
    endfunction

    // The slot index is ignored on an offer; randomize it anyway.
    function automatic t_item offer_beat(logic [SOL_W-1:0] sol, int a, int b, int c, int d);
        t_item beat;
        beat.cmd        = CMD_OFFER;
        beat.read_index = IDX_W'($urandom);
        beat.sol_bits   = sol;
        beat.obj_a      = a;
        beat.obj_b      = b;
        beat.obj_c      = c;
        beat.obj_d      = d;
        return beat;
    endfunction

    // Payload fields are ignored on a read; fill them with noise.
    function automatic t_item read_beat(int slot);
        t_item beat;
        beat            = offer_beat(any_sol(), $urandom, $urandom, $urandom, $urandom);
        beat.cmd        = CMD_READ;
        beat.read_index = IDX_W'(slot);
        return beat;
    endfunction

    // Hold start low for random idle cycles, then present the beat and hold
    // it until the block takes it. Return on the following falling edge so
    // the next call may keep start high without a glitch.
    task automatic send_beat(input t_item beat);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= beat;
        do @(posedge i_clk); while (busy);
        archive_sb.note_item(beat);
        @(negedge i_clk);
    endtask

    // Write the objective count only once the archive has gone quiet: all
    // results back and busy low.
    task automatic write_objective_count(input logic [NUM_OBJ_W-1:0] value);
        start <= 1'b0;
        while (archive_sb.pending.size() != 0 || busy)
            @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        archive_sb.obj_count_reg = value;
    endtask

    // Random offer: mostly close to a live entry so that dominance goes both
    // ways; the rest small-range or full-range noise.
    task automatic offer_random();
        int unsigned roll;
        t_objs       base;
        roll = $urandom_range(99);
        if (roll < 15) begin
            send_beat(offer_beat(any_sol(), $urandom, $urandom, $urandom, $urandom));
        end else if (roll < 30 || !archive_sb.pick_live(base, 1'b0)) begin
            send_beat(offer_beat(any_sol(), int'($urandom_range(8)) - 4,
                int'($urandom_range(8)) - 4, int'($urandom_range(8)) - 4,
                int'($urandom_range(8)) - 4));
        end else begin
            send_beat(offer_beat(any_sol(), nudge(base[0], int'($urandom_range(6)) - 3),
                nudge(base[1], int'($urandom_range(6)) - 3),
                nudge(base[2], int'($urandom_range(6)) - 3),
                nudge(base[3], int'($urandom_range(6)) - 3)));
        end
    endtask

    // Drive the archive to full and past it. With one lane, stack duplicates
    // of the leading entry; otherwise lay an anti-chain next to a live entry
    // (lane 0 up, lane 1 down). Then offer a dominated candidate on a full
    // archive, one that frees slots and takes one (with one lane, an equal one instead), and one that sweeps most.
    task automatic fill_archive();
        t_objs       anchor;
        int unsigned lanes;
        int          span;
        int          slot;
        lanes = archive_sb.active_lanes();
        span  = ARCHIVE_DEPTH_DEF + 2;
        if (!archive_sb.pick_live(anchor, lanes == 1)) begin
            foreach (anchor[i])
                anchor[i] = int'($urandom_range(200)) - 100;
        end
        for (int i = 1; i <= span; i++) begin
            if (lanes == 1)
                send_beat(offer_beat(any_sol(), anchor[0], $urandom, $urandom, $urandom));
            else
                send_beat(offer_beat(any_sol(), nudge(anchor[0], i), nudge(anchor[1], -i),
                    anchor[2], anchor[3]));
        end
        if (lanes == 1) begin
            send_beat(offer_beat(any_sol(), nudge(anchor[0], -1), 0, 0, 0));
            send_beat(offer_beat(any_sol(), anchor[0], 0, 0, 0));
            send_beat(offer_beat(any_sol(), nudge(anchor[0], 1), 0, 0, 0));
        end else begin
            send_beat(offer_beat(any_sol(), nudge(anchor[0], 1), nudge(anchor[1], -2),
                anchor[2], anchor[3]));
            send_beat(offer_beat(any_sol(), nudge(anchor[0], 4), nudge(anchor[1], -3),
                anchor[2], anchor[3]));
            send_beat(offer_beat(any_sol(), nudge(anchor[0], span), nudge(anchor[1], -1),
                anchor[2], anchor[3]));
        end
        // Read back the top slot and a few others; some were just invalidated.
        if (archive_sb.slot_touched[SLOTS-1])
            send_beat(read_beat(SLOTS - 1));
        repeat (3) begin
            slot = archive_sb.pick_touched();
            send_beat(read_beat(slot));
        end
    endtask

    // One phase: new objective count, new sender idle rate, optional fill,
    // then a mix of reads of touched slots and random offers. Reads only go
    // to slots that have held an entry, never to a slot not yet written.
    task automatic run_phase(input logic [NUM_OBJ_W-1:0] obj_count, input int unsigned idle_pct,
                             input bit with_fill, input int unsigned count);
        int slot;
        write_objective_count(obj_count);
        sender_idle_pct = idle_pct;
        if (with_fill)
            fill_archive();
        repeat (count) begin
            slot = archive_sb.pick_touched();
            if ($urandom_range(99) < 25 && slot >= 0)
                send_beat(read_beat(slot));
            else
                offer_random();
        end
    endtask

    initial begin
        archive_sb      = new();
        sender_idle_pct = 9;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_item          = '0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = NUM_OBJ_RESET;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the reset objective count of two.
        send_beat(offer_beat(64'h0, 0, 0, 0, 0));                     // empty archive
        send_beat(offer_beat('1, 0, 0, OBJ_TOP, OBJ_BOTTOM));         // equal: keep duplicate
        send_beat(read_beat(0));
        send_beat(read_beat(1));
        send_beat(offer_beat(64'hAAAA_AAAA_AAAA_AAAA, 1, 0, OBJ_BOTTOM, OBJ_BOTTOM)); // drop 2
        send_beat(read_beat(1));                                      // slot now invalid
        send_beat(offer_beat(any_sol(), 0, -1, OBJ_TOP, OBJ_TOP));    // dominated: dropped
        send_beat(offer_beat(any_sol(), 1, 0, 5, 7));                 // unused lanes differ
        send_beat(offer_beat(64'h5555_5555_5555_5555, 100, 100, -1, -1));
        send_beat(read_beat(0));
        send_beat(read_beat(1));
        send_beat(offer_beat(any_sol(), OBJ_BOTTOM, OBJ_TOP, OBJ_TOP, OBJ_BOTTOM));
        send_beat(offer_beat(any_sol(), OBJ_BOTTOM, OBJ_BOTTOM, OBJ_TOP, OBJ_TOP));
        send_beat(offer_beat(any_sol(), 101, 99, OBJ_BOTTOM, OBJ_TOP));
        send_beat(offer_beat(any_sol(), -1, -1, -1, -1));
        send_beat(read_beat(1));
        send_beat(read_beat(2));
        send_beat(read_beat(3));

        // Random phases: sender idles 9%, then 51%, then never. The counts
        // sweep both ends of the register, zero acting as one and seven as
        // four.
        run_phase(3'd1, 9, 1'b1, 30);
        run_phase(3'd4, 9, 1'b0, 30);
        run_phase(3'd3, 51, 1'b1, 30);
        run_phase(3'd0, 51, 1'b0, 30);
        run_phase(3'd7, 0, 1'b1, 30);
        run_phase(3'd6, 0, 1'b0, 30);

        // Drain: wait for every result, then one more offer's worth of cycles
        // so a stray beat would still be caught.
        start <= 1'b0;
        while (archive_sb.pending.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (archive_sb.mismatches == 0 && archive_sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: sim.f
design/paf_pkg.sv
design/paf_lane.sv
design/paf_merge.sv
design/paf_store.sv
design/pareto_archive_filter_core.sv
tb/sv/archive_scoreboard_pkg.sv
tb/sv/tb.sv
